[rtl/xbf_pkg.sv]
`default_nettype none

package xbf_pkg;

    localparam int          BLOCK_BYTES_DEF = 128;
    localparam logic [7:0]  SOH_BYTE        = 8'h01;
    localparam logic [15:0] CRC_POLY        = 16'h1021;

    localparam logic [1:0]  RUN_DATA_ONLY   = 2'd0;
    localparam logic [1:0]  RUN_SUM_TRAILER = 2'd1;
    localparam logic [1:0]  RUN_CRC_TRAILER = 2'd2;
    localparam logic [1:0]  RUN_HEADER      = 2'd3;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            trailer;
    } burst_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

[rtl/xbf_framer.sv]
`default_nettype none

module xbf_framer
    import xbf_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire logic [7:0] data,
    input  wire logic [7:0] num,
    input  wire logic       crc_mode,
    output burst_t          burst
);

    localparam int PW = $clog2(BLOCK_BYTES);

    logic [PW-1:0] pos_reg, pos_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    sum_reg, sum_next;
    logic          first;
    logic          last;
    logic [15:0]   crc_base;
    logic [7:0]    sum_base;

    assign first    = (pos_reg == '0);
    assign last     = (pos_reg == PW'(BLOCK_BYTES - 1));
    assign crc_base = first ? 16'h0000 : crc_reg;
    assign sum_base = first ? 8'h00 : sum_reg;
    assign crc_next = crc_fold(crc_base, data);
    assign sum_next = sum_base + data;
    assign pos_next = last ? '0 : pos_reg + PW'(1);

    always_comb
    begin
        burst.bytes    = '0;
        burst.last_idx = RUN_DATA_ONLY;
        burst.trailer  = 1'b0;
        if (first)
        begin
            burst.bytes[0] = SOH_BYTE;
            burst.bytes[1] = num;
            burst.bytes[2] = 8'hFF - num;
            burst.bytes[3] = data;
            burst.last_idx = RUN_HEADER;
        end
        else if (last)
        begin
            burst.bytes[0] = data;
            burst.trailer  = 1'b1;
            if (crc_mode)
            begin
                burst.bytes[1] = crc_next[15:8];
                burst.bytes[2] = crc_next[7:0];
                burst.last_idx = RUN_CRC_TRAILER;
            end
            else
            begin
                burst.bytes[1] = sum_next;
                burst.last_idx = RUN_SUM_TRAILER;
            end
        end
        else
        begin
            burst.bytes[0] = data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= '0;
            sum_reg <= '0;
        end
        else if (load)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

[rtl/xmodem_block_framer.sv]
`default_nettype none

// XMODEM block framer. Each accepted item is one payload byte; a block of
// BLOCK_BYTES items becomes one packet: SOH, block number, its complement,
// the data bytes, then the 8-bit sum (crc_mode 0) or CRC-16 high and low
// (crc_mode 1, poly 0x1021, init 0). block_number is used on a block's first
// byte only. The output emits one byte per cycle while out_stall is low, so
// an item makes 4 bytes on a block's first byte, 2 or 3 on its last, and 1
// otherwise; a new item is taken each cycle the one-byte-per-cycle output
// serializer can absorb it. Write cfg_we/cfg_wdata only while idle.

module xmodem_block_framer
    import xbf_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] payload_byte,
    input  wire logic [7:0] block_number,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      tx_byte,
    output logic            last_of_run,
    output logic            packet_done
);

    logic       mode_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] in_num_reg;
    burst_t     burst_new;
    burst_t     burst_reg;
    logic       burst_valid_reg;
    logic [1:0] burst_idx_reg;
    logic       out_valid_reg;
    logic [7:0] tx_byte_reg;
    logic       last_reg;
    logic       done_reg;
    logic       out_free;
    logic       burst_emit;
    logic       burst_at_end;
    logic       burst_emit_last;
    logic       burst_load;

    assign out_free        = !out_valid_reg || !out_stall;
    assign burst_emit      = burst_valid_reg && out_free;
    assign burst_at_end    = (burst_idx_reg == burst_reg.last_idx);
    assign burst_emit_last = burst_emit && burst_at_end;
    assign burst_load      = in_valid_reg && (!burst_valid_reg || burst_emit_last);
    assign in_stall        = in_valid_reg && !burst_load;

    assign out_valid   = out_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign last_of_run = last_reg;
    assign packet_done = done_reg;

    xbf_framer #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (burst_load),
        .data     (in_byte_reg),
        .num      (in_num_reg),
        .crc_mode (mode_reg),
        .burst    (burst_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= payload_byte;
            in_num_reg  <= block_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            burst_idx_reg   <= '0;
        end
        else if (burst_load)
        begin
            burst_valid_reg <= 1'b1;
            burst_idx_reg   <= '0;
        end
        else if (burst_emit)
        begin
            if (burst_at_end)
                burst_valid_reg <= 1'b0;
            else
                burst_idx_reg <= burst_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_load)
            burst_reg <= burst_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= burst_emit;
    end

    always_ff @(posedge clk)
    begin
        if (burst_emit)
        begin
            tx_byte_reg <= burst_reg.bytes[burst_idx_reg];
            last_reg    <= burst_at_end;
            done_reg    <= burst_at_end && burst_reg.trailer;
        end
    end

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> last_reg)
        else $error("packet_done without last_of_run");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg |-> burst_idx_reg <= burst_reg.last_idx)
        else $error("burst index past end of run");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg && !burst_emit_last |-> !burst_load)
        else $error("burst reloaded before run finished");

    a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
        burst_emit && !burst_at_end && !burst_load |=>
            burst_valid_reg && burst_idx_reg == $past(burst_idx_reg) + 2'd1)
        else $error("burst index did not advance");

endmodule

`default_nettype wire

[tb/xbf_checker.sv]
module xbf_checker
    import xbf_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] payload_byte,
    input  wire logic [7:0] block_number,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] tx_byte,
    input  wire logic       last_of_run,
    input  wire logic       packet_done,
    output int              fail_count,
    output int              pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       pkt_end;
    } framed_byte_t;

    framed_byte_t expected_bytes[$];

    logic        use_crc;
    int          position;
    logic [15:0] crc_acc;
    logic [7:0]  sum_acc;

    function automatic logic [15:0] crc16_next(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ data[i];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    task automatic expect_byte(input logic [7:0] value, input logic run_end,
                               input logic pkt_end);
        framed_byte_t b;
        b.value   = value;
        b.run_end = run_end;
        b.pkt_end = pkt_end;
        expected_bytes.push_back(b);
    endtask

    task automatic frame_item(input logic [7:0] data, input logic [7:0] number);
        logic is_last;
        is_last = (position == BLOCK_BYTES - 1);
        if (position == 0)
        begin
            crc_acc = '0;
            sum_acc = '0;
            expect_byte(SOH_BYTE, 1'b0, 1'b0);
            expect_byte(number, 1'b0, 1'b0);
            expect_byte(~number, 1'b0, 1'b0);
        end
        crc_acc = crc16_next(crc_acc, data);
        sum_acc = sum_acc + data;
        expect_byte(data, !is_last, 1'b0);
        if (is_last)
        begin
            if (use_crc)
            begin
                expect_byte(crc_acc[15:8], 1'b0, 1'b0);
                expect_byte(crc_acc[7:0], 1'b1, 1'b1);
            end
            else
            begin
                expect_byte(sum_acc, 1'b1, 1'b1);
            end
            position = 0;
        end
        else
        begin
            position++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        framed_byte_t want;
        if (!rst_n)
        begin
            use_crc    = 1'b0;
            position   = 0;
            crc_acc    = '0;
            sum_acc    = '0;
            expected_bytes.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
                use_crc = cfg_wdata;
            if (in_valid && !in_stall)
                frame_item(payload_byte, block_number);
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, got byte %02h last %b done %b",
                             $time, tx_byte, last_of_run, packet_done);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (tx_byte !== want.value || last_of_run !== want.run_end ||
                        packet_done !== want.pkt_end)
                    begin
                        $display("%0t: expected byte %02h last %b done %b, got byte %02h last %b done %b",
                                 $time, want.value, want.run_end, want.pkt_end,
                                 tx_byte, last_of_run, packet_done);
                        fail_count++;
                    end
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

[tb/xmodem_block_framer_tb.sv]
module xmodem_block_framer_tb;
    import xbf_pkg::*;

    localparam int BLOCK_LEN   = BLOCK_BYTES_DEF;
    localparam int PHASE_ITEMS = 90;
    localparam int CYCLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       cfg_we       = 1'b0;
    logic       cfg_wdata    = 1'b0;
    logic       in_valid     = 1'b0;
    logic       out_stall    = 1'b0;
    logic [7:0] payload_byte = 8'h00;
    logic [7:0] block_number = 8'h00;

    wire logic       in_stall;
    wire logic       out_valid;
    wire logic [7:0] tx_byte;
    wire logic       last_of_run;
    wire logic       packet_done;

    int mismatches;
    int pending;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int items_sent   = 0;
    int block_starts = 0;
    int cycles       = 0;

    xmodem_block_framer #(
        .BLOCK_BYTES (BLOCK_LEN)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_byte      (tx_byte),
        .last_of_run  (last_of_run),
        .packet_done  (packet_done)
    );

    xbf_checker #(
        .BLOCK_BYTES (BLOCK_LEN)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tx_byte      (tx_byte),
        .last_of_run  (last_of_run),
        .packet_done  (packet_done),
        .fail_count   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic [7:0] data);
        logic [7:0] number;
        number = $urandom_range(0, 255);
        if (items_sent % BLOCK_LEN == 0)
        begin
            if (block_starts == 0)
                number = 8'h00;
            else if (block_starts == 1)
                number = 8'hFF;
            block_starts++;
        end
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        payload_byte <= data;
        block_number <= number;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_mode(input logic crc_on);
        cfg_we    <= 1'b1;
        cfg_wdata <= crc_on;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int n, input int idle, input int stall, input int pause_at);
        idle_pct   = idle;
        stall_pct <= stall;
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                drain();
            send_item($urandom_range(0, 255));
        end
    endtask

    initial
    begin
        logic [7:0] edge_bytes [0:23];
        edge_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'hAA, 8'h55,
                       8'h0F, 8'hF0, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h10, 8'h21,
                       8'h02, 8'h04, 8'h08, 8'h20, 8'h40, 8'h33, 8'hCC, 8'h5A};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 24; i++)
            send_item(edge_bytes[i]);

        // mode flips land mid-block; trailers at 128 (crc), 256 (sum), 384 (crc)
        drain();
        write_mode(1'b1);
        run_phase(PHASE_ITEMS, 0, 0, -1);
        drain();
        run_phase(PHASE_ITEMS, 47, 0, PHASE_ITEMS / 2);
        drain();
        write_mode(1'b0);
        run_phase(PHASE_ITEMS, 0, 47, -1);
        drain();
        write_mode(1'b1);
        run_phase(PHASE_ITEMS, 9, 9, -1);
        drain();
        repeat (16) @(negedge clk);

        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
